>>> rtl/cpq_pkg.sv
// Package for the circular process queue with a maximum-priority scan.
// Holds the entry record, the per-cell control struct and the operation codes.
// No dependencies.
`timescale 1ns / 1ps

package cpq_pkg;

  // One queued process record.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [7:0]  prio;
  } entry_t;

  // Control handed from the top level to every cell of the row.
  typedef struct packed {
    logic shift_en;   // take the neighbor's record (dequeue)
    logic load_en;    // take the incoming record (enqueue)
    logic occupied;   // this cell holds a live entry
  } cell_ctrl_t;

  // Operation codes of the input item.
  localparam logic [1:0] FUNC_ENQ     = 2'd0;
  localparam logic [1:0] FUNC_DEQ     = 2'd1;
  localparam logic [1:0] FUNC_INSPECT = 2'd2;

  // Status codes of the result item.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

endpackage

>>> rtl/cpq_cell.sv
// One cell of the queue row: holds a single record and one stage of the
// running maximum that travels from the tail side toward the head.
// Depends on cpq_pkg.
`timescale 1ns / 1ps

module cpq_cell (
  input  logic              clk,
  input  cpq_pkg::cell_ctrl_t ctrl,
  input  cpq_pkg::entry_t   load_data,
  input  cpq_pkg::entry_t   nbr_data,
  input  logic [7:0]        max_in,
  output cpq_pkg::entry_t   data,
  output logic [7:0]        max_out
);
  import cpq_pkg::*;

  entry_t     data_r;
  entry_t     data_nxt;
  logic [7:0] max_r;
  logic [7:0] max_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load_en) begin
      data_nxt = load_data;
    end else if (ctrl.shift_en) begin
      data_nxt = nbr_data;
    end
  end

  // An empty cell passes the maximum of the cells behind it unchanged.
  assign max_nxt = (ctrl.occupied && (data_r.prio > max_in)) ? data_r.prio : max_in;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    max_r  <= max_nxt;
  end

  assign data    = data_r;
  assign max_out = max_r;

endmodule

>>> rtl/circular_process_queue_max_priority.sv
// Top level of the circular process queue with a maximum-priority scan.
// Instantiates a row of cpq_cell and the control around it; uses cpq_pkg.
`timescale 1ns / 1ps

// Usage:
// Each input item (in_valid/in_ready) is an enqueue, a dequeue of the head or
// an inspect. Every item produces exactly one result item (out_valid/out_ready)
// with the status, the empty flag, the entry count, the head record and the
// largest priority among the occupied entries, all after the operation.
// The queue is a row of QUEUE_DEPTH cells with the head in cell 0. An enqueue
// writes the cell just past the last live one; a dequeue moves every record
// one cell toward the head. A running maximum moves one cell per cycle from
// the tail end toward cell 0; the scan settles once it has crossed the row.
// The result is offered once the scan has settled, and no new item is taken
// until that result has gone into the output register, so the length of
// the maximum chain sets the pace of the queue.
// Reset (synchronous, rst_n low) empties the queue and drops any pending
// result; the record storage itself is not cleared. While the receiver
// stalls, the finished result waits in the output register and one more item
// may be accepted; its result is held back until the output register frees.
module circular_process_queue_max_priority #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_burst_time,
  input  logic [7:0]  in_priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_empty_res,
  output logic [4:0]  out_entry_count,
  output logic [15:0] out_head_id,
  output logic [15:0] out_head_burst,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_highest_priority
);
  import cpq_pkg::*;

  // Count width: must hold QUEUE_DEPTH itself.
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Controller states: waiting for an item, or letting the maximum settle.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic            state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [1:0]      status_r, status_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r;
  logic            out_empty_r;
  logic [4:0]      out_count_r;
  entry_t          out_head_r;
  logic [7:0]      out_max_r;

  logic            in_accept;
  logic            out_accept;
  logic            is_full;
  logic            is_empty;
  logic            do_enq;
  logic            do_deq;
  logic            scan_done;
  logic            out_free;
  entry_t          load_data;

  entry_t          cell_data [QUEUE_DEPTH];
  logic [7:0]      cell_max  [QUEUE_DEPTH];
  cell_ctrl_t      cell_ctrl [QUEUE_DEPTH];

  assign in_ready   = (state_r == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid_r && out_ready;

  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // A full enqueue or an empty dequeue leaves the queue untouched.
  assign do_enq = in_accept && (in_func == FUNC_ENQ) && !is_full;
  assign do_deq = in_accept && (in_func == FUNC_DEQ) && !is_empty;

  assign load_data = '{id: in_process_id, burst: in_burst_time, prio: in_priority_req};

  // Row of cells. The last cell feeds back its own record and takes a zero maximum: a dequeue
  // leaves a stale record there, which lies past the count and is ignored.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].shift_en = do_deq;
    assign cell_ctrl[i].load_en  = do_enq && (count_r == CW'(i));
    assign cell_ctrl[i].occupied = (CW'(i) < count_r);

    if (i == QUEUE_DEPTH - 1) begin : g_last
      cpq_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[i]),
        .load_data(load_data),
        .nbr_data (cell_data[i]),
        .max_in   (8'd0),
        .data     (cell_data[i]),
        .max_out  (cell_max[i])
      );
    end else begin : g_mid
      cpq_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[i]),
        .load_data(load_data),
        .nbr_data (cell_data[i+1]),
        .max_in   (cell_max[i+1]),
        .data     (cell_data[i]),
        .max_out  (cell_max[i])
      );
    end
  end

  // The head cell's maximum covers the whole row once the scan counter has run
  // to its end since the contents last changed.
  assign scan_done = (state_r == ST_SCAN) && (scan_cnt_r == CW'(QUEUE_DEPTH));
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_cnt_nxt = scan_cnt_r;
    status_nxt   = status_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
          status_nxt   = STAT_OK;
          if (in_func == FUNC_ENQ && is_full) begin
            status_nxt = STAT_FULL;
          end else if (in_func == FUNC_DEQ && is_empty) begin
            status_nxt = STAT_UNDERFLOW;
          end
          if (do_enq) begin
            count_nxt = count_r + CW'(1);
          end else if (do_deq) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (scan_done && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_accept) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; the head record and the maximum read zero when empty.
  always_ff @(posedge clk) begin
    if (scan_done && out_free) begin
      out_status_r <= status_r;
      out_empty_r  <= is_empty;
      out_count_r  <= 5'(count_r);
      out_head_r   <= is_empty ? '0 : cell_data[0];
      out_max_r    <= is_empty ? 8'd0 : cell_max[0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_empty_res        = out_empty_r;
  assign out_entry_count      = out_count_r;
  assign out_head_id          = out_head_r.id;
  assign out_head_burst       = out_head_r.burst;
  assign out_head_priority    = out_head_r.prio;
  assign out_highest_priority = out_max_r;

  // The entry count never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // The occupancy moves only when an item is accepted.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(count_r))
    else $error("entry count changed without an accepted item");

  // An accepted item always starts a scan, so no second item slips in.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_SCAN) && !in_ready)
    else $error("accepted item did not start a scan");

  // An empty result carries a zero head priority, a zero maximum and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |->
      (out_highest_priority == 8'd0) && (out_head_priority == 8'd0) &&
      (out_entry_count == 5'd0))
    else $error("empty result carries nonzero fields");

endmodule

>>> sim/tb_circular_process_queue_max_priority.sv
// Self-checking testbench for circular_process_queue_max_priority.
// Drives a directed table and then random enqueue/dequeue/inspect traffic and
// checks each result against a shadow ring model. Depends on cpq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_circular_process_queue_max_priority;
  import cpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;

  // Code 3 has no name in the package; the block treats it as an inspect.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1000;
  // The last stretch of random items runs with neither side idling.
  localparam int CALM_TAIL    = 150;
  // Item index at which the receiver starts its one long hold-off.
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  // Quiet window after the last result, well past the time one item takes.
  localparam int SETTLE_CYCLES = 4 * (QUEUE_DEPTH + 2);
  // Watchdog bound: room for about 1000 items, several times over.
  localparam int CYCLE_LIMIT  = 500000;

  // Snapshot of the queue after one operation, field for field as on the ports.
  typedef struct packed {
    logic [1:0]  status;
    logic        empty;
    logic [4:0]  count;
    logic [15:0] head_id;
    logic [15:0] head_burst;
    logic [7:0]  head_prio;
    logic [7:0]  highest;
  } queue_view_t;

  // One row of the directed table. Where typed is set, the view in the row is
  // the expected result; otherwise the shadow model supplies it.
  typedef struct {
    logic [1:0]  func;
    entry_t      rec;
    bit          typed;
    queue_view_t view;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_INSPECT;
  logic [15:0] in_process_id = '0;
  logic [15:0] in_burst_time = '0;
  logic [7:0]  in_priority_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_empty_res;
  logic [4:0]  out_entry_count;
  logic [15:0] out_head_id;
  logic [15:0] out_head_burst;
  logic [7:0]  out_head_priority;
  logic [7:0]  out_highest_priority;

  circular_process_queue_max_priority #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_process_id       (in_process_id),
    .in_burst_time       (in_burst_time),
    .in_priority_req     (in_priority_req),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_empty_res       (out_empty_res),
    .out_entry_count     (out_entry_count),
    .out_head_id         (out_head_id),
    .out_head_burst      (out_head_burst),
    .out_head_priority   (out_head_priority),
    .out_highest_priority(out_highest_priority)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the ring. Slots are only read while occupied, so their
  // content before the first write never matters.
  entry_t ring_slots [QUEUE_DEPTH];
  int     ring_head = 0;
  int     ring_tail = 0;
  int     ring_fill = 0;

  // Results still owed by the block, oldest first.
  queue_view_t pending_views[$];
  int          errors = 0;
  int          cycle_count = 0;

  // Knobs that the stimulus process sets and the receiver process follows.
  int stall_pct = 15;
  bit hold_request = 1'b0;
  bit calm_tail = 1'b0;

  // Applies one operation to the shadow ring and returns the queue as it
  // stands afterwards. A full enqueue and an empty dequeue leave the ring
  // alone; draining the last entry sends both pointers back to slot 0.
  function automatic queue_view_t apply_op(logic [1:0] f, entry_t rec);
    queue_view_t v;
    int          slot;
    v = '0;
    v.status = STAT_OK;
    case (f)
      FUNC_ENQ: begin
        if (ring_fill >= QUEUE_DEPTH) begin
          v.status = STAT_FULL;
        end else begin
          ring_slots[ring_tail] = rec;
          ring_tail = (ring_tail + 1 >= QUEUE_DEPTH) ? 0 : ring_tail + 1;
          ring_fill++;
        end
      end
      FUNC_DEQ: begin
        if (ring_fill == 0) begin
          v.status = STAT_UNDERFLOW;
        end else begin
          ring_fill--;
          if (ring_fill == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end else begin
            ring_head = (ring_head + 1 >= QUEUE_DEPTH) ? 0 : ring_head + 1;
          end
        end
      end
      default: begin
        // Inspect and the spare code change nothing.
      end
    endcase
    v.empty = (ring_fill == 0);
    v.count = ring_fill[4:0];
    if (ring_fill != 0) begin
      v.head_id    = ring_slots[ring_head].id;
      v.head_burst = ring_slots[ring_head].burst;
      v.head_prio  = ring_slots[ring_head].prio;
      slot = ring_head;
      for (int n = 0; n < ring_fill; n++) begin
        if (ring_slots[slot].prio > v.highest) v.highest = ring_slots[slot].prio;
        slot = (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
      end
    end
    return v;
  endfunction

  function automatic queue_view_t view_of(logic [1:0] st, logic emp, logic [4:0] cnt,
                                          logic [15:0] id, logic [15:0] burst,
                                          logic [7:0] prio, logic [7:0] hi);
    queue_view_t v;
    v.status     = st;
    v.empty      = emp;
    v.count      = cnt;
    v.head_id    = id;
    v.head_burst = burst;
    v.head_prio  = prio;
    v.highest    = hi;
    return v;
  endfunction

  function automatic plan_row_t plan_row(logic [1:0] f, logic [15:0] id, logic [15:0] burst,
                                         logic [7:0] prio, bit typed, queue_view_t v);
    plan_row_t r;
    r.func  = f;
    r.rec   = '{id: id, burst: burst, prio: prio};
    r.typed = typed;
    r.view  = v;
    return r;
  endfunction

  // Offers one item and holds it until the block takes it. The shadow model
  // advances at the accepting edge, so expectations queue up in input order.
  task automatic offer_item(input logic [1:0] f, input entry_t rec, input bit typed,
                            input queue_view_t typed_view);
    queue_view_t predicted;
    in_valid        <= 1'b1;
    in_func         <= f;
    in_process_id   <= rec.id;
    in_burst_time   <= rec.burst;
    in_priority_req <= rec.prio;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = apply_op(f, rec);
    pending_views.push_back(typed ? typed_view : predicted);
  endtask

  // Random gap on the input side: with pct percent chance, valid drops before the next item.
  task automatic maybe_idle(input int pct);
    int gap;
    if ($urandom_range(0, 99) < pct) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: reset, the directed table, then random traffic that swings
  // between filling and draining phases so that both full and empty come up
  // again and again, with the ring pointers wrapping at random offsets.
  initial begin
    plan_row_t   plan[$];
    queue_view_t none;
    entry_t      rec;
    logic [1:0]  f;
    int          enq_pct;
    int          idle_pct;
    int          pick;

    none = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Right after reset the queue is empty and everything reads 0.
    plan.push_back(plan_row(FUNC_INSPECT, 16'h0, 16'h0, 8'h0, 1'b1,
                            view_of(STAT_OK, 1'b1, 5'd0, 16'h0, 16'h0, 8'h0, 8'h0)));
    // Dequeue on an empty queue is an underflow.
    plan.push_back(plan_row(FUNC_DEQ, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                            view_of(STAT_UNDERFLOW, 1'b1, 5'd0, 16'h0, 16'h0, 8'h0, 8'h0)));
    // All-ones record becomes the head and the highest priority.
    plan.push_back(plan_row(FUNC_ENQ, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                            view_of(STAT_OK, 1'b0, 5'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF)));
    // Removing the only entry empties the queue; the pointers go back to 0.
    plan.push_back(plan_row(FUNC_DEQ, 16'h0, 16'h0, 8'h0, 1'b1,
                            view_of(STAT_OK, 1'b1, 5'd0, 16'h0, 16'h0, 8'h0, 8'h0)));
    // All-zero record: a live entry whose priority is 0.
    plan.push_back(plan_row(FUNC_ENQ, 16'h0, 16'h0, 8'h0, 1'b1,
                            view_of(STAT_OK, 1'b0, 5'd1, 16'h0, 16'h0, 8'h0, 8'h0)));
    // The spare code behaves as an inspect; its payload is ignored.
    plan.push_back(plan_row(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                            view_of(STAT_OK, 1'b0, 5'd1, 16'h0, 16'h0, 8'h0, 8'h0)));
    // Fill up with rising priorities; the last one reaches 255.
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      plan.push_back(plan_row(FUNC_ENQ, 16'(16'h1111 * i), 16'(~(16'h1111 * i)),
                              8'(17 * i), 1'b0, none));
    end
    // Enqueue on a full queue is dropped.
    plan.push_back(plan_row(FUNC_ENQ, 16'hA5A5, 16'h5A5A, 8'hFF, 1'b1,
                            view_of(STAT_FULL, 1'b0, 5'd16, 16'h0, 16'h0, 8'h0, 8'hFF)));
    plan.push_back(plan_row(FUNC_INSPECT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, none));
    plan.push_back(plan_row(FUNC_DEQ, 16'h0, 16'h0, 8'h0, 1'b0, none));

    idle_pct = 15;
    foreach (plan[i]) begin
      offer_item(plan[i].func, plan[i].rec, plan[i].typed, plan[i].view);
      maybe_idle(idle_pct);
    end

    enq_pct = 50;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Every 32 items pick a new direction and new idling levels; some
      // windows have no idling at all. The calm tail keeps idling off.
      if (k % 32 == 0) begin
        enq_pct = ($urandom_range(0, 1) == 0) ? 70 : 25;
        if (k < RANDOM_ITEMS - CALM_TAIL) begin
          idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 15;
          stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : 15;
        end
      end
      if (k == RANDOM_ITEMS - CALM_TAIL) begin
        idle_pct = 0;
        stall_pct <= 0;
        calm_tail <= 1'b1;
      end
      if (k == HOLD_AT) hold_request <= 1'b1;

      pick = $urandom_range(0, 99);
      if (pick < enq_pct) f = FUNC_ENQ;
      else if (pick < 90) f = FUNC_DEQ;
      else if (pick < 97) f = FUNC_INSPECT;
      else f = FUNC_SPARE;

      rec.id    = 16'($urandom);
      rec.burst = 16'($urandom);
      case ($urandom_range(0, 9))
        0: rec.prio = 8'h00;
        1: rec.prio = 8'hFF;
        default: rec.prio = 8'($urandom);
      endcase

      offer_item(f, rec, 1'b0, none);
      maybe_idle(idle_pct);
    end
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    // Any stray result in this window is caught by the result checker.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: short random stalls, one long hold-off that lets the queue
  // back up into the input channel, and no stalls in the calm tail.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0 && !calm_tail) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 10) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    queue_view_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_views.size() == 0) begin
        $error("result item arrived with no item outstanding");
        errors++;
      end else begin
        want = pending_views.pop_front();
        check_field("status",           16'(want.status),     16'(out_status));
        check_field("empty_res",        16'(want.empty),      16'(out_empty_res));
        check_field("entry_count",      16'(want.count),      16'(out_entry_count));
        check_field("head_id",          want.head_id,         out_head_id);
        check_field("head_burst",       want.head_burst,      out_head_burst);
        check_field("head_priority",    16'(want.head_prio),  16'(out_head_priority));
        check_field("highest_priority", 16'(want.highest),    16'(out_highest_priority));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

>>> circular_process_queue_max_priority.f
rtl/cpq_pkg.sv
rtl/cpq_cell.sv
rtl/circular_process_queue_max_priority.sv
sim/tb_circular_process_queue_max_priority.sv
